/* hdl/upe_pkg.sv */
package upe_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_W-1:0] CAP_RESET   = 16'd256;
    localparam logic [COUNT_W-1:0] SLACK_BYTES = 16'd4;

    localparam logic [BYTE_W-1:0] CHAR_TERM    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] HEX_ALPHA    = 8'd55;
    localparam logic [BYTE_W-1:0] HEX_DIGIT    = 8'd48;

    // one queued job for the back end: a literal byte or a byte to escape
    typedef struct packed {
        logic              esc;
        logic [BYTE_W-1:0] data;
    } upe_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HI   = 3'b010,
        ST_LO   = 3'b100
    } upe_state_t;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        wide = {4'b0000, nib};
        return (nib > 4'd9) ? wide + HEX_ALPHA : wide + HEX_DIGIT;
    endfunction

    function automatic logic passes_through(input logic [BYTE_W-1:0] c);
        logic ok;
        ok = ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h30) && (c <= 8'h39));
        case (c)
            8'h3D, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

endpackage

/* hdl/url_percent_encoder_top.sv */
// Each queued entry is stored in the queue, then loaded into the output register.
// Throughput: one input beat per cycle while the queue is not full; an escaped
// byte becomes three output bytes, one per cycle while m_tready is high.
// A two-entry queue decouples input classification from output sequencing.
// Reset (aresetn low, synchronous): queue and output empty, count 0, capacity 256.
module url_percent_encoder_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [upe_pkg::COUNT_W-1:0] cfg_data,   // dest_capacity
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [upe_pkg::BYTE_W-1:0]  s_tdata,    // [7:0] in_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [upe_pkg::BYTE_W-1:0]  m_tdata,    // [7:0] out_byte
    output logic                        m_tlast
);

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_not_empty;
    upe_pkg::upe_entry_t q_wdata;
    upe_pkg::upe_entry_t q_rdata;

    upe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_byte   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    upe_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_not_empty)
    );

    upe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_byte    (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

/* hdl/upe_fifo.sv */
module upe_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  upe_pkg::upe_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output upe_pkg::upe_entry_t pop_data,
    output logic                not_empty
);

    upe_pkg::upe_entry_t                  mem_reg [upe_pkg::FIFO_DEPTH];
    logic [upe_pkg::FIFO_AW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [upe_pkg::FIFO_AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [upe_pkg::FIFO_CW-1:0]          count_reg, count_next;

    localparam logic [upe_pkg::FIFO_CW-1:0] DEPTH_C = upe_pkg::FIFO_CW'(upe_pkg::FIFO_DEPTH);
    localparam logic [upe_pkg::FIFO_AW-1:0] LAST_C  = upe_pkg::FIFO_AW'(upe_pkg::FIFO_DEPTH - 1);

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/upe_front.sv */
module upe_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [upe_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [upe_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         q_full,
    output logic                         q_push,
    output upe_pkg::upe_entry_t          q_data
);

    logic [upe_pkg::COUNT_W-1:0] cap_reg, cap_next;
    logic [upe_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [upe_pkg::COUNT_W-1:0] limit;
    logic [upe_pkg::COUNT_W:0]   sum;
    logic [1:0]                  n_out;
    logic                        accept;
    logic                        is_term;
    logic                        is_lit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    assign limit   = (cap_reg > upe_pkg::SLACK_BYTES) ? cap_reg - upe_pkg::SLACK_BYTES : '0;
    assign is_term = (in_byte == upe_pkg::CHAR_TERM);
    assign is_lit  = (in_byte == upe_pkg::CHAR_SPACE) || upe_pkg::passes_through(in_byte);
    assign n_out   = is_lit ? 2'd1 : 2'd3;
    assign sum     = {1'b0, count_reg} + {{(upe_pkg::COUNT_W-1){1'b0}}, n_out};

    always_comb begin
        cap_next   = cap_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        q_data.esc  = !is_lit;
        q_data.data = (in_byte == upe_pkg::CHAR_SPACE) ? upe_pkg::CHAR_PLUS : in_byte;
        if (cfg_valid) begin
            cap_next = cfg_data;
        end
        if (accept) begin
            if (is_term) begin
                q_push      = 1'b1;
                q_data.esc  = 1'b0;
                q_data.data = upe_pkg::CHAR_TERM;
                count_next  = '0;
            end else if (count_reg < limit) begin
                q_push     = 1'b1;
                count_next = sum[upe_pkg::COUNT_W] ? '1 : sum[upe_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= upe_pkg::CAP_RESET;
            count_reg <= '0;
        end else begin
            cap_reg   <= cap_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/upe_back.sv */
module upe_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_not_empty,
    input  upe_pkg::upe_entry_t         q_data,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [upe_pkg::BYTE_W-1:0]  out_byte,
    output logic                        m_tlast
);

    upe_pkg::upe_state_t          state_reg, state_next;
    logic [upe_pkg::BYTE_W-1:0]   esc_reg, esc_next;
    logic [upe_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic                         last_reg, last_next;
    logic                         valid_reg, valid_next;
    logic                         slot_free;

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign out_byte  = byte_reg;
    assign m_tlast   = last_reg;

    always_comb begin
        state_next = state_reg;
        esc_next   = esc_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;
        q_pop      = 1'b0;
        if (slot_free) begin
            case (state_reg)
                upe_pkg::ST_HI: begin
                    byte_next  = upe_pkg::hex_char(esc_reg[7:4]);
                    last_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = upe_pkg::ST_LO;
                end
                upe_pkg::ST_LO: begin
                    byte_next  = upe_pkg::hex_char(esc_reg[3:0]);
                    last_next  = 1'b1;
                    valid_next = 1'b1;
                    state_next = upe_pkg::ST_IDLE;
                end
                default: begin
                    if (q_not_empty) begin
                        q_pop      = 1'b1;
                        valid_next = 1'b1;
                        if (q_data.esc) begin
                            byte_next  = upe_pkg::CHAR_PERCENT;
                            last_next  = 1'b0;
                            esc_next   = q_data.data;
                            state_next = upe_pkg::ST_HI;
                        end else begin
                            byte_next = q_data.data;
                            last_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= upe_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        esc_reg  <= esc_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule
